[rtl/b58_pkg.sv]
// Shared types, constants and helper functions for the base-58 encoder.
`default_nettype none

package b58_pkg;

  localparam int unsigned RADIX        = 58;
  localparam int unsigned RESULT_LIMIT = 45;
  localparam int unsigned KW           = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned DIGIT_W      = 6;
  localparam int unsigned SUM_W        = 14;
  localparam int unsigned RECIP_58     = 1130;  // 2^16 / 58, rounded up
  localparam logic [6:0]  CHAR_ONE     = 7'h31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EXT,
    S_EMIT_RD,
    S_EMIT_LD
  } b58_state_e;

  typedef struct packed {
    logic take_in;
    logic walk;
    logic ext;
    logic emit_rd;
    logic emit_ld;
    logic clear;
  } b58_cmd_t;

  typedef struct packed {
    logic accepted;
    logic fold_take;
    logic last_in;
    logic final_flag;
    logic count_zero;
    logic walk_last;
    logic ext_more;
    logic n_zero;
    logic emit_last;
    logic out_free;
  } b58_stat_t;

  // Quotient and remainder of x / 58 for x below 58 * 256, by reciprocal.
  function automatic logic [13:0] div58(input logic [SUM_W-1:0] x);
    logic [24:0]      prod;
    logic [7:0]       quo;
    logic [SUM_W-1:0] rem;
    prod = 25'(x) * 25'(RECIP_58);
    quo  = prod[23:16];
    rem  = x - SUM_W'(SUM_W'(quo) * SUM_W'(RADIX));
    return {quo, rem[DIGIT_W-1:0]};
  endfunction

  // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z.
  function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < 6'd9) begin
      c = 7'h31 + 7'(d);
    end else if (d < 6'd17) begin
      c = 7'h41 + 7'(d - 6'd9);
    end else if (d < 6'd22) begin
      c = 7'h4A + 7'(d - 6'd17);
    end else if (d < 6'd33) begin
      c = 7'h50 + 7'(d - 6'd22);
    end else if (d < 6'd44) begin
      c = 7'h61 + 7'(d - 6'd33);
    end else if (d < 6'd58) begin
      c = 7'h6D + 7'(d - 6'd44);
    end else begin
      c = CHAR_ONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/b58_in_if.sv]
// Byte input channel: valid/ready with data byte and final-byte flag.
`default_nettype none

interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/b58_out_if.sv]
// Character output channel: valid/ready with character and flags.
`default_nettype none

interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;
  logic       too_long;

  modport source (output valid, output out_char, output last_char, output too_long,
                  input ready);
  modport sink   (input valid, input out_char, input last_char, input too_long,
                  output ready);
endinterface

`default_nettype wire

[rtl/b58_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module b58_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 45
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/b58_ctrl.sv]
// Sequencer for byte intake, carry walk, digit growth and character output.
`default_nettype none

module b58_ctrl
  import b58_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire b58_stat_t stat_i,
  output b58_cmd_t       cmd_o
);

  b58_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.take_in = 1'b1;
        if (stat_i.accepted) begin
          if (stat_i.fold_take) begin
            state_d = stat_i.count_zero ? S_EXT : S_WALK;
          end else if (stat_i.last_in) begin
            state_d = S_EMIT_RD;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_EXT;
        end
      end
      S_EXT: begin
        if (stat_i.ext_more) begin
          cmd_o.ext = 1'b1;
        end else begin
          state_d = stat_i.final_flag ? S_EMIT_RD : S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (stat_i.n_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.emit_rd = 1'b1;
          state_d       = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        if (stat_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (stat_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/b58_dpath.sv]
// Digit store, counters, shared divide-by-58 unit and output register.
`default_nettype none

module b58_dpath
  import b58_pkg::*;
#(
  parameter int unsigned MAX_BYTES  = 32,
  parameter int unsigned MAX_DIGITS = 45
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire b58_cmd_t cmd_i,
  output b58_stat_t     stat_o,
  b58_in_if.sink        in_i,
  b58_out_if.source     out_o
);

  localparam int unsigned BCW = $clog2(MAX_BYTES + 1);
  localparam int unsigned CW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW  = $clog2(MAX_DIGITS);
  localparam int unsigned TW  = $clog2(MAX_BYTES + MAX_DIGITS + RESULT_LIMIT + 1);

  logic [BCW-1:0]     byte_cnt_q, zero_cnt_q;
  logic [CW-1:0]      dcnt_q;
  logic [AW-1:0]      j_q;
  logic [KW-1:0]      k_q;
  logic [7:0]         carry_q;
  logic               seen_q, ovf_q, final_q;
  logic               out_valid_q;
  logic [6:0]         out_char_q;
  logic               out_last_q, out_long_q;

  logic               accepted, in_range, fold_take;
  logic [SUM_W-1:0]   div_in;
  logic [13:0]        div_out;
  logic [7:0]         quo;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rdata;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [TW-1:0]      total, idx_full;
  logic [KW-1:0]      n_chars;
  logic               is_one, emit_last;

  assign in_i.ready = cmd_i.take_in;
  assign accepted   = in_i.valid & in_i.ready;
  assign in_range   = byte_cnt_q < BCW'(MAX_BYTES);
  assign fold_take  = accepted & in_range & (seen_q | (in_i.data_byte != 8'd0));

  // carry + digit * 256 is just the digit above the carry byte
  assign div_in  = cmd_i.walk ? {rdata, carry_q} : {6'd0, carry_q};
  assign div_out = div58(div_in);
  assign quo     = div_out[13:6];
  assign rem     = div_out[5:0];

  assign total     = TW'(zero_cnt_q) + TW'(dcnt_q);
  assign n_chars   = (total > TW'(RESULT_LIMIT)) ? KW'(RESULT_LIMIT) : KW'(total);
  assign is_one    = TW'(k_q) < TW'(zero_cnt_q);
  assign emit_last = (TW'(k_q) + TW'(1)) == TW'(n_chars);
  assign idx_full  = TW'(dcnt_q) + TW'(zero_cnt_q) - TW'(k_q) - TW'(1);

  assign we    = cmd_i.walk | cmd_i.ext;
  assign waddr = cmd_i.walk ? j_q : dcnt_q[AW-1:0];
  assign re    = cmd_i.walk | cmd_i.emit_rd | cmd_i.take_in;

  always_comb begin
    if (cmd_i.walk) begin
      raddr = AW'(j_q + AW'(1));
    end else if (cmd_i.emit_rd) begin
      raddr = idx_full[AW-1:0];
    end else begin
      raddr = '0;
    end
  end

  b58_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rem),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      zero_cnt_q <= '0;
      dcnt_q     <= '0;
      j_q        <= '0;
      k_q        <= '0;
      seen_q     <= 1'b0;
      ovf_q      <= 1'b0;
      final_q    <= 1'b0;
    end else if (cmd_i.clear) begin
      byte_cnt_q <= '0;
      zero_cnt_q <= '0;
      dcnt_q     <= '0;
      j_q        <= '0;
      k_q        <= '0;
      seen_q     <= 1'b0;
      ovf_q      <= 1'b0;
      final_q    <= 1'b0;
    end else begin
      if (accepted) begin
        final_q <= in_i.last_byte;
        j_q     <= '0;
        if (in_range) begin
          byte_cnt_q <= byte_cnt_q + BCW'(1);
          if (!seen_q && in_i.data_byte == 8'd0) begin
            zero_cnt_q <= zero_cnt_q + BCW'(1);
          end else begin
            seen_q <= 1'b1;
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.walk) begin
        j_q <= AW'(j_q + AW'(1));
      end
      if (cmd_i.ext) begin
        dcnt_q <= dcnt_q + CW'(1);
      end
      if (cmd_i.emit_ld) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  // carry is payload: load the byte on a fold, advance on every divide step
  always_ff @(posedge clk_i) begin
    if (fold_take) begin
      carry_q <= in_i.data_byte;
    end else if (cmd_i.walk || cmd_i.ext) begin
      carry_q <= quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_char_q <= is_one ? CHAR_ONE : b58_char(rdata);
      out_last_q <= emit_last;
      out_long_q <= ovf_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.last_char = out_last_q;
  assign out_o.too_long  = out_long_q;

  always_comb begin
    stat_o            = '0;
    stat_o.accepted   = accepted;
    stat_o.fold_take  = fold_take;
    stat_o.last_in    = in_i.last_byte;
    stat_o.final_flag = final_q;
    stat_o.count_zero = dcnt_q == '0;
    stat_o.walk_last  = (CW'(j_q) + CW'(1)) == dcnt_q;
    stat_o.ext_more   = (carry_q != 8'd0) && (dcnt_q < CW'(MAX_DIGITS));
    stat_o.n_zero     = n_chars == '0;
    stat_o.emit_last  = emit_last;
    stat_o.out_free   = !out_valid_q || out_o.ready;
  end

endmodule

`default_nettype wire

[rtl/base58_encoder_top.sv]
// Top level of the base-58 (Bitcoin alphabet) byte string encoder.
`default_nettype none

// Bytes arrive one per word on in_i, most significant first, last_byte on the
// final one; the encoded text leaves one character per word on out_o, with
// last_char on its final character and too_long on every character when
// bytes past MAX_BYTES were dropped. A leading zero byte, or a dropped byte,
// only updates the counters and flags; the block stays ready unless it was
// the final byte. Any other byte is folded in by a carry walk that visits
// each stored base-58 digit once through the single read port of the digit
// RAM and the one shared divide-by-58 unit, and the stored value then grows
// by at most two digits. After the final byte each character is read from
// the digit RAM, then loaded into the output register once that is free. The
// next message's first byte is taken while the last character still waits
// in the output register. The digit RAM needs no clearing after reset.
module base58_encoder_top
  import b58_pkg::*;
#(
  parameter int unsigned MAX_BYTES  = 32,
  parameter int unsigned MAX_DIGITS = 45
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b58_in_if.sink    in_i,
  b58_out_if.source out_o
);

  b58_cmd_t  cmd;
  b58_stat_t stat;

  b58_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  b58_dpath #(
    .MAX_BYTES  (MAX_BYTES),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // at most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_in, cmd.walk, cmd.ext, cmd.emit_rd, cmd.emit_ld}))
    else $error("more than one datapath command active");

  // a byte that neither folds nor ends the message leaves the block ready
  a_quick_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.accepted && !stat.fold_take && !stat.last_in |=> in_i.ready)
    else $error("not ready after a counted or dropped byte");

  // loading the final character frees the input side at once
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_ld && stat.emit_last |=> in_i.ready && out_o.valid && out_o.last_char)
    else $error("final character load did not return to intake");

  // a clear only ever comes with the final character or an empty text
  a_clear_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> (cmd.emit_ld && stat.emit_last) || stat.n_zero)
    else $error("message state cleared early");

endmodule

`default_nettype wire
